// File: hdl/bagrp_pkg.sv
// Shared types and constants for the bag record header parser.
// Holds the parse phase encoding, the result record and the name characters.
// No dependencies.
`default_nettype none

package bagrp_pkg;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_LEN   = 6'b000001,  // header length bytes
        PH_FLEN  = 6'b000010,  // field length bytes
        PH_NAME  = 6'b000100,  // field name characters
        PH_NZERO = 6'b001000,  // name ended by a zero byte
        PH_VALUE = 6'b010000,  // value bytes of a recognized field
        PH_SKIP  = 6'b100000   // rest of an unrecognized field
    } t_phase;

    // Name match flags
    localparam logic [1:0] MATCH_NONE = 2'b00;
    localparam logic [1:0] MATCH_OP   = 2'b01;
    localparam logic [1:0] MATCH_CONN = 2'b10;
    localparam logic [1:0] MATCH_BOTH = 2'b11;

    localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [2:0] NAME_MAX  = 3'd5;
    localparam logic [2:0] OP_LEN    = 3'd2;
    localparam logic [2:0] CONN_LEN  = 3'd4;
    localparam logic [2:0] VALUE_MAX = 3'd4;

    // Bytes of the header length word itself
    localparam logic [31:0] LEN_WORD_BYTES = 32'd4;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    // One result per header
    typedef struct packed {
        logic [31:0] op_value;
        logic        op_found;
        logic [31:0] conn_value;
        logic        conn_found;
        logic [31:0] header_bytes;
        logic        status;
    } t_result;

    // Expected character of "op" at a name position
    function automatic logic [7:0] op_char(input logic pos);
        return pos ? 8'h70 : 8'h6F;
    endfunction

    // Expected character of "conn" at a name position
    function automatic logic [7:0] conn_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h63;
            2'd1:    c = 8'h6F;
            default: c = 8'h6E;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bagrp_core.sv
// Parse state and single-byte step of the bag record header parser.
// Advances the header, field, name and value trackers by one byte per step.
// Depends on bagrp_pkg.
`default_nettype none

module bagrp_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire [7:0]            i_data_byte,
    input  wire                  i_restart,
    output logic                 o_res_valid,
    output bagrp_pkg::t_result   o_res
);

    bagrp_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_byte_index, n_byte_index;
    logic [31:0] r_header_length, n_header_length;
    logic [31:0] r_header_left, n_header_left;
    logic [31:0] r_field_left, n_field_left;
    logic [2:0]  r_name_count, n_name_count;
    logic [2:0]  r_name_len, n_name_len;
    logic [1:0]  r_name_match, n_name_match;
    logic [31:0] r_value_accum, n_value_accum;
    logic [2:0]  r_value_shift, n_value_shift;
    logic        r_value_stopped, n_value_stopped;
    logic [31:0] r_op_reg, n_op_reg;
    logic [31:0] r_conn_reg, n_conn_reg;
    logic [1:0]  r_found, n_found;

    logic        field_done;
    logic        header_done;
    logic [1:0]  match_tmp;
    logic [31:0] store_val;

    // Narrow the candidate set once the name is complete
    function automatic logic [1:0] resolve(input logic [1:0] m, input logic [2:0] len);
        logic [1:0] r;
        r = bagrp_pkg::MATCH_NONE;
        if (m[0] && len == bagrp_pkg::OP_LEN) begin
            r = bagrp_pkg::MATCH_OP;
        end else if (m[1] && len == bagrp_pkg::CONN_LEN) begin
            r = bagrp_pkg::MATCH_CONN;
        end
        return r;
    endfunction

    // One byte of work
    always_comb begin
        n_phase         = r_phase;
        n_byte_index    = r_byte_index;
        n_header_length = r_header_length;
        n_header_left   = r_header_left;
        n_field_left    = r_field_left;
        n_name_count    = r_name_count;
        n_name_len      = r_name_len;
        n_name_match    = r_name_match;
        n_value_accum   = r_value_accum;
        n_value_shift   = r_value_shift;
        n_value_stopped = r_value_stopped;
        n_op_reg        = r_op_reg;
        n_conn_reg      = r_conn_reg;
        n_found         = r_found;
        field_done      = 1'b0;
        header_done     = 1'b0;
        match_tmp       = r_name_match;
        store_val       = 32'd0;
        o_res_valid     = 1'b0;
        o_res           = '0;

        if (i_restart) begin
            n_phase      = bagrp_pkg::PH_LEN;
            n_byte_index = 2'd0;
        end

        if (n_phase == bagrp_pkg::PH_LEN) begin
            // Collect the header length, little-endian
            case (n_byte_index)
                2'd0: n_header_length = {24'd0, i_data_byte};
                2'd1: n_header_length[15:8]  = n_header_length[15:8] | i_data_byte;
                2'd2: n_header_length[23:16] = n_header_length[23:16] | i_data_byte;
                default: n_header_length[31:24] = n_header_length[31:24] | i_data_byte;
            endcase
            if (n_byte_index != 2'd3) begin
                n_byte_index = n_byte_index + 2'd1;
            end else begin
                n_byte_index = 2'd0;
                if (n_header_length == 32'd0 || n_header_length[31]) begin
                    // Reject a zero or negative length at once
                    o_res_valid        = 1'b1;
                    o_res.header_bytes = bagrp_pkg::LEN_WORD_BYTES;
                    o_res.status       = bagrp_pkg::STATUS_BAD_LEN;
                end else begin
                    n_header_left = n_header_length;
                    n_op_reg      = 32'd0;
                    n_conn_reg    = 32'd0;
                    n_found       = 2'b00;
                    n_field_left  = 32'd0;
                    n_phase       = bagrp_pkg::PH_FLEN;
                end
            end
        end else begin
            if (n_phase == bagrp_pkg::PH_FLEN) begin
                // Collect the field length, little-endian
                case (n_byte_index)
                    2'd0: n_field_left = {24'd0, i_data_byte};
                    2'd1: n_field_left[15:8]  = n_field_left[15:8] | i_data_byte;
                    2'd2: n_field_left[23:16] = n_field_left[23:16] | i_data_byte;
                    default: n_field_left[31:24] = n_field_left[31:24] | i_data_byte;
                endcase
                if (n_byte_index != 2'd3) begin
                    n_byte_index = n_byte_index + 2'd1;
                end else begin
                    n_byte_index = 2'd0;
                    if (n_field_left != 32'd0) begin
                        n_phase         = bagrp_pkg::PH_NAME;
                        n_name_count    = 3'd0;
                        n_name_len      = 3'd0;
                        n_name_match    = bagrp_pkg::MATCH_BOTH;
                        n_value_accum   = 32'd0;
                        n_value_shift   = 3'd0;
                        n_value_stopped = 1'b0;
                    end
                end
            end else begin
                // Field body byte
                if (n_phase == bagrp_pkg::PH_NAME || n_phase == bagrp_pkg::PH_NZERO) begin
                    if (i_data_byte == bagrp_pkg::CHAR_EQ) begin
                        n_name_match = resolve(n_name_match, n_name_len);
                        if (n_name_match != bagrp_pkg::MATCH_NONE) begin
                            n_phase = bagrp_pkg::PH_VALUE;
                        end else begin
                            n_phase = bagrp_pkg::PH_SKIP;
                        end
                    end else if (n_name_count >= bagrp_pkg::NAME_MAX) begin
                        // Overlong name: this byte already belongs to the value
                        n_name_match = resolve(n_name_match, n_name_len);
                        if (n_name_match != bagrp_pkg::MATCH_NONE) begin
                            n_phase = bagrp_pkg::PH_VALUE;
                            if (i_data_byte == bagrp_pkg::CHAR_NUL) begin
                                n_value_stopped = 1'b1;
                            end else begin
                                n_value_accum[7:0] = n_value_accum[7:0] | i_data_byte;
                                n_value_shift = n_value_shift + 3'd1;
                            end
                        end else begin
                            n_phase = bagrp_pkg::PH_SKIP;
                        end
                    end else begin
                        if (n_phase == bagrp_pkg::PH_NAME) begin
                            if (i_data_byte == bagrp_pkg::CHAR_NUL) begin
                                n_phase = bagrp_pkg::PH_NZERO;
                            end else begin
                                match_tmp = n_name_match;
                                if (!(n_name_count < 3'd2 &&
                                      i_data_byte == bagrp_pkg::op_char(n_name_count[0]))) begin
                                    match_tmp[0] = 1'b0;
                                end
                                if (!(n_name_count < 3'd4 &&
                                      i_data_byte == bagrp_pkg::conn_char(n_name_count[1:0]))) begin
                                    match_tmp[1] = 1'b0;
                                end
                                n_name_match = match_tmp;
                                n_name_len   = n_name_len + 3'd1;
                            end
                        end
                        n_name_count = n_name_count + 3'd1;
                    end
                end else if (n_phase == bagrp_pkg::PH_VALUE) begin
                    // Pack the first four value bytes little-endian, stopping at a zero byte
                    if (!n_value_stopped) begin
                        if (i_data_byte == bagrp_pkg::CHAR_NUL) begin
                            n_value_stopped = 1'b1;
                        end else if (n_value_shift < bagrp_pkg::VALUE_MAX) begin
                            case (n_value_shift[1:0])
                                2'd0: n_value_accum[7:0] = n_value_accum[7:0] | i_data_byte;
                                2'd1: n_value_accum[15:8] = n_value_accum[15:8] | i_data_byte;
                                2'd2: n_value_accum[23:16] =
                                          n_value_accum[23:16] | i_data_byte;
                                default: n_value_accum[31:24] =
                                          n_value_accum[31:24] | i_data_byte;
                            endcase
                            n_value_shift = n_value_shift + 3'd1;
                        end
                    end
                end
                n_field_left = n_field_left - 32'd1;
                field_done   = (n_field_left == 32'd0);
            end

            n_header_left = n_header_left - 32'd1;
            header_done   = (n_header_left == 32'd0);

            // Close the field at its own end or at the header end
            if (field_done || (header_done && n_phase != bagrp_pkg::PH_FLEN)) begin
                if (n_phase == bagrp_pkg::PH_NAME || n_phase == bagrp_pkg::PH_NZERO) begin
                    n_name_match = resolve(n_name_match, n_name_len);
                    store_val    = 32'd0;
                end else begin
                    store_val    = n_value_accum;
                end
                if (n_phase == bagrp_pkg::PH_NAME || n_phase == bagrp_pkg::PH_NZERO ||
                    n_phase == bagrp_pkg::PH_VALUE) begin
                    if (n_name_match == bagrp_pkg::MATCH_OP) begin
                        n_op_reg   = store_val;
                        n_found[0] = 1'b1;
                    end else if (n_name_match == bagrp_pkg::MATCH_CONN) begin
                        n_conn_reg = store_val;
                        n_found[1] = 1'b1;
                    end
                end
                n_phase      = bagrp_pkg::PH_FLEN;
                n_byte_index = 2'd0;
                n_field_left = 32'd0;
            end

            // Emit the header result
            if (header_done) begin
                o_res_valid        = 1'b1;
                o_res.op_value     = n_op_reg;
                o_res.op_found     = n_found[0];
                o_res.conn_value   = n_conn_reg;
                o_res.conn_found   = n_found[1];
                o_res.header_bytes = n_header_length + bagrp_pkg::LEN_WORD_BYTES;
                o_res.status       = bagrp_pkg::STATUS_OK;
                n_phase            = bagrp_pkg::PH_LEN;
                n_byte_index       = 2'd0;
            end
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    // Update state only on a processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= bagrp_pkg::PH_LEN;
            r_byte_index    <= 2'd0;
            r_header_length <= 32'd0;
            r_header_left   <= 32'd0;
            r_field_left    <= 32'd0;
            r_name_count    <= 3'd0;
            r_name_len      <= 3'd0;
            r_name_match    <= bagrp_pkg::MATCH_BOTH;
            r_value_accum   <= 32'd0;
            r_value_shift   <= 3'd0;
            r_value_stopped <= 1'b0;
            r_op_reg        <= 32'd0;
            r_conn_reg      <= 32'd0;
            r_found         <= 2'b00;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_byte_index    <= n_byte_index;
            r_header_length <= n_header_length;
            r_header_left   <= n_header_left;
            r_field_left    <= n_field_left;
            r_name_count    <= n_name_count;
            r_name_len      <= n_name_len;
            r_name_match    <= n_name_match;
            r_value_accum   <= n_value_accum;
            r_value_shift   <= n_value_shift;
            r_value_stopped <= n_value_stopped;
            r_op_reg        <= n_op_reg;
            r_conn_reg      <= n_conn_reg;
            r_found         <= n_found;
        end
    end

    // Length byte counting happens only while reading a length word
    a_index_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index != 2'd0 |->
            (r_phase == bagrp_pkg::PH_LEN || r_phase == bagrp_pkg::PH_FLEN))
        else $error("byte index advanced outside a length word");

    // Name counters stay bounded and consistent
    a_name_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_count <= bagrp_pkg::NAME_MAX && r_name_len <= r_name_count)
        else $error("name counters out of range");

    // Value bytes past the fourth never count
    a_value_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_value_shift <= bagrp_pkg::VALUE_MAX)
        else $error("value shift beyond four bytes");

    // A rejected length reports nothing but the length word
    a_bad_len_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == bagrp_pkg::STATUS_BAD_LEN) |->
            (o_res.header_bytes == bagrp_pkg::LEN_WORD_BYTES &&
             !o_res.op_found && !o_res.conn_found))
        else $error("bad length result carries field data");

endmodule

`default_nettype wire

// File: hdl/bagrp_out_reg.sv
// Result register of the bag record header parser.
// Holds one header result until the receiver takes it; frees for reload on transfer.
// Depends on bagrp_pkg.
`default_nettype none

module bagrp_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  bagrp_pkg::t_result   i_res,
    input  wire                  i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output bagrp_pkg::t_result   o_res
);

    logic               r_valid;
    bagrp_pkg::t_result r_res;

    // Free when empty or draining this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bag_record_header_parser.sv
// Top level of the bag record header parser: input register, parse core, result register.
// Depends on bagrp_pkg, bagrp_core and bagrp_out_reg.
//
// Use: header stream bytes enter on the s_axis channel, one per transfer; tuser[0]
// set forces the byte to be the first length byte of a new header, dropping any
// partial header. One result leaves on the m_axis channel per header, after its
// last byte, or after the fourth length byte when the length is zero or negative
// (status in tuser[0] is then 1 and header_bytes is 4).
// Throughput: one byte per cycle unless a waiting result stalls the input; every byte
// is a single step of the parse core. Path: the last byte of a header sits in the
// input register, and the result register loads the result when the parse core
// steps on that byte; the result then stays on m_axis until it transfers.
// Stall: while a result waits in the result register, the byte in the input
// register holds and tready stays high only if the input register is empty.
// Reset: synchronous, active low; clears the valid flags of both registers and returns the parser
// to expecting the first header length byte.
`default_nettype none

module bag_record_header_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire  [0:0]   i_s_axis_tuser,   // [0] restart
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // [31:0] op_value, [32] op_found,
                                           // [64:33] conn_value, [65] conn_found,
                                           // [97:66] header_bytes, [103:98] zero
    output logic [0:0]   o_m_axis_tuser    // [0] status
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_restart;
    logic               w_step;
    logic               w_out_free;
    logic               w_res_valid;
    bagrp_pkg::t_result w_res;
    bagrp_pkg::t_result w_out_res;

    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    // Input register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_restart <= i_s_axis_tuser[0];
        end
    end

    bagrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_in_byte),
        .i_restart   (r_in_restart),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bagrp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_out_res)
    );

    // Pack the result fields, lowest first
    assign o_m_axis_tdata = {6'd0, w_out_res.header_bytes, w_out_res.conn_found,
                             w_out_res.conn_value, w_out_res.op_found,
                             w_out_res.op_value};
    assign o_m_axis_tuser = w_out_res.status;

    // A held byte is never lost while the result side is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_byte) &&
                                         $stable(r_in_restart)))
        else $error("input register changed while stalled");

    // A result is produced only from a processed byte
    a_res_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_step)
        else $error("result without a processed byte");

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
